### design/psi_pkg.sv
`default_nettype none
package psi_pkg;

  // Q-format and word widths
  localparam int FB     = 16;            // fraction bits
  localparam int CW     = 32;            // coordinate width
  localparam int NW     = FB + 2;        // normal component width
  localparam int VW     = 63;            // internal signed value, holds +-(2^62 - 1)
  localparam int UW     = VW - 1;        // magnitude of an internal value
  localparam int XW     = 2 * CW + FB + 3; // widest product / sum
  localparam int AW     = CW + FB + 2;   // multiplier A operand (t or distance)
  localparam int SPLIT  = 32;            // low slice of A for the split multiply
  localparam int PLW    = SPLIT + CW + 2;
  localparam int PHW    = AW - SPLIT + CW + 1;
  localparam int QB     = UW;            // quotient bits out of the divider
  localparam int SMALLW = 33;            // magnitudes below 2^33 may pass the 1e-9 test
  localparam int EW     = 30;
  localparam int EPSW   = SMALLW + EW;

  localparam logic [EW-1:0] EPS_INV = EW'(1000000000);
  localparam logic signed [VW-1:0] LIM = {1'b0, {(VW-1){1'b1}}};
  localparam logic signed [VW:0] HALF = {{(VW-FB+1){1'b0}}, 1'b1, {(FB-1){1'b0}}};
  localparam logic signed [VW-1:0] ONE = {{(VW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};
  localparam logic signed [CW-1:0] ONE_CW = {{(CW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}};

  typedef enum logic [1:0] {
    REG_NORMAL_X,
    REG_NORMAL_Y,
    REG_NORMAL_Z,
    REG_PLANE_OFFSET
  } reg_idx_t;

  typedef enum logic {
    CMD_INTERSECT,
    CMD_PROJECT
  } cmd_t;

  typedef struct packed {
    cmd_t                 cmd;
    logic signed [CW-1:0] start_x;
    logic signed [CW-1:0] start_y;
    logic signed [CW-1:0] start_z;
    logic signed [CW-1:0] end_x;
    logic signed [CW-1:0] end_y;
    logic signed [CW-1:0] end_z;
  } in_t;

  typedef struct packed {
    logic signed [CW-1:0] point_x;
    logic signed [CW-1:0] point_y;
    logic signed [CW-1:0] point_z;
    logic signed [CW-1:0] t_value;
    logic                 hit;
    logic signed [CW-1:0] signed_distance;
  } out_t;

  // per-item data riding alongside the arithmetic
  typedef struct packed {
    cmd_t                 cmd;
    logic [2:0][CW-1:0]   s;     // start point
    logic [2:0][CW:0]     ed;    // end - start
    logic signed [VW-1:0] sdist; // rounded distance
    logic                 par;   // div == 0
    logic                 st;    // start in plane
    logic                 ec;    // end in plane
    logic                 neg;   // num, div of opposite sign
    logic                 hitg;  // |num| <= |div|
    logic                 sat;   // quotient overflows
  } side_t;

  function automatic logic signed [VW-1:0] clamp_lim(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    hi = XW'(LIM);
    lo = -hi;
    if (x > hi) return LIM;
    if (x < lo) return -LIM;
    return x[VW-1:0];
  endfunction

  function automatic logic signed [CW-1:0] sat_cw(input logic signed [XW-1:0] x);
    logic signed [XW-1:0] hi;
    logic signed [XW-1:0] lo;
    hi = {{(XW-CW+1){1'b0}}, {(CW-1){1'b1}}};
    lo = ~hi;
    if (x > hi) return hi[CW-1:0];
    if (x < lo) return lo[CW-1:0];
    return x[CW-1:0];
  endfunction

  function automatic logic signed [AW-1:0] clamp_a(input logic signed [VW-1:0] x);
    logic signed [VW-1:0] hi;
    logic signed [VW-1:0] lo;
    hi = {{(VW-AW+1){1'b0}}, {(AW-1){1'b1}}};
    lo = -hi;
    if (x > hi) return hi[AW-1:0];
    if (x < lo) return lo[AW-1:0];
    return x[AW-1:0];
  endfunction

  // round half up, drop FB fraction bits
  function automatic logic signed [VW-1:0] rnd(input logic signed [VW-1:0] x);
    logic signed [VW:0] y;
    y = (VW+1)'(x) + HALF;
    return VW'(y >>> FB);
  endfunction

endpackage
`default_nettype wire

### design/plane_segment_intersect_top.sv
`default_nettype none
// channel   direction  handshake              beat
// in        in         in_valid / in_stall    in_t  (cmd, start, end)
// out       out        out_valid / out_stall  out_t (point, t, hit, distance)
// cfg       in         cfg_valid / cfg_ready  cfg_index, cfg_data
//
// One beat enters per clock while in_stall is low; each result leaves through
// 6 front stages (dot products, 1e-9 endpoint tests), 63 divider stages
// (an entry register, then one quotient bit of t per stage), 4 back stages
// (split multiply, round, add).
// Reset is synchronous and clears valids and the plane registers (n = +z, d = 0).
// A stalled full output register freezes the whole pipe, so in_stall follows
// out_stall while out_valid is high; nothing is dropped or replayed.
module plane_segment_intersect_top
  import psi_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  in_t           in_data,
  output logic          out_valid,
  input  logic          out_stall,
  output out_t          out_data,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [1:0]    cfg_index,
  input  logic [CW-1:0] cfg_data
);

  // plane registers
  logic signed [NW-1:0] nrm [3];
  logic signed [CW-1:0] offset;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      nrm[0] <= '0;
      nrm[1] <= '0;
      nrm[2] <= NW'(ONE);
      offset <= '0;
    end else if (cfg_valid) begin
      unique case (reg_idx_t'(cfg_index))
        REG_NORMAL_X:     nrm[0] <= cfg_data[NW-1:0];
        REG_NORMAL_Y:     nrm[1] <= cfg_data[NW-1:0];
        REG_NORMAL_Z:     nrm[2] <= cfg_data[NW-1:0];
        REG_PLANE_OFFSET: offset <= cfg_data;
        default:          offset <= offset;
      endcase
    end
  end

  // global advance: every stage moves unless the output beat is held
  logic en;
  assign en = !(out_valid && out_stall);
  assign in_stall = !en;

  logic          f_valid;
  logic [UW-1:0] f_an, f_ad;
  side_t         f_side;

  psi_front u_front (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .nrm       (nrm),
    .offset    (offset),
    .out_valid (f_valid),
    .an_out    (f_an),
    .ad_out    (f_ad),
    .side_out  (f_side)
  );

  logic          d_valid;
  logic [QB-1:0] d_q;
  side_t         d_side;

  psi_div u_div (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (f_valid),
    .an        (f_an),
    .ad        (f_ad),
    .side_in   (f_side),
    .out_valid (d_valid),
    .q_out     (d_q),
    .side_out  (d_side)
  );

  psi_back u_back (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (d_valid),
    .q         (d_q),
    .side_in   (d_side),
    .nrm       (nrm),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

`ifndef SYNTH
  // a hit always lies on the segment
  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.hit |->
      out_data.t_value >= 0 && out_data.t_value <= ONE_CW)
    else $error("hit with t outside 0..1");

  // input backpressure only comes from a held output beat
  a_stall_src: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output stall");

  // pipe is empty right after reset
  a_rst_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("output valid after reset");
`endif

endmodule
`default_nettype wire

### design/psi_front.sv
`default_nettype none
module psi_front
  import psi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  in_t                  in_data,
  input  logic signed [NW-1:0] nrm [3],
  input  logic signed [CW-1:0] offset,
  output logic                 out_valid,
  output logic [UW-1:0]        an_out,
  output logic [UW-1:0]        ad_out,
  output side_t                side_out
);

  logic signed [CW-1:0] sv [3];
  logic signed [CW-1:0] ev [3];
  logic signed [CW:0]   sdv [3];
  side_t                sd0;

  always_comb begin
    sv[0] = in_data.start_x;
    sv[1] = in_data.start_y;
    sv[2] = in_data.start_z;
    ev[0] = in_data.end_x;
    ev[1] = in_data.end_y;
    ev[2] = in_data.end_z;
    sd0 = '0;
    sd0.cmd = in_data.cmd;
    for (int i = 0; i < 3; i++) begin
      sdv[i] = (CW+1)'(sv[i]) - (CW+1)'(ev[i]);
      sd0.s[i] = sv[i];
      sd0.ed[i] = (CW+1)'(ev[i]) - (CW+1)'(sv[i]);
    end
  end

  // S1: products
  logic                    v1;
  side_t                   sd1;
  logic signed [NW+CW-1:0] pns [3];
  logic signed [NW+CW:0]   pnd [3];
  logic signed [CW-1:0]    off1;

  always_ff @(posedge clk) begin
    if (en) begin
      sd1 <= sd0;
      off1 <= offset;
      for (int i = 0; i < 3; i++) begin
        pns[i] <= nrm[i] * sv[i];
        pnd[i] <= nrm[i] * sdv[i];
      end
    end
  end

  // S2: clamp, first partial sums
  logic                 v2;
  side_t                sd2;
  logic signed [VW-1:0] nab, dab, nc, dc, offc;

  always_ff @(posedge clk) begin
    if (en) begin
      sd2 <= sd1;
      nab <= clamp_lim(XW'(clamp_lim(XW'(pns[0]))) + XW'(clamp_lim(XW'(pns[1]))));
      dab <= clamp_lim(XW'(clamp_lim(XW'(pnd[0]))) + XW'(clamp_lim(XW'(pnd[1]))));
      nc <= clamp_lim(XW'(pns[2]));
      dc <= clamp_lim(XW'(pnd[2]));
      offc <= clamp_lim(XW'(off1) <<< FB);
    end
  end

  // S3: num, div
  logic                 v3;
  side_t                sd3;
  logic signed [VW-1:0] num, dvs;
  logic signed [VW-1:0] numab;

  assign numab = clamp_lim(XW'(nab) + XW'(nc));

  always_ff @(posedge clk) begin
    if (en) begin
      sd3 <= sd2;
      num <= clamp_lim(XW'(numab) + XW'(offc));
      dvs <= clamp_lim(XW'(dab) + XW'(dc));
    end
  end

  // S4: magnitudes, flags, rounded distance
  logic                 v4;
  side_t                sd4, sd4_next;
  logic [UW-1:0]        an4, ad4;
  logic [SMALLW-1:0]    amd4;
  logic                 sn4, smd4;
  logic signed [VW-1:0] an_s, ad_s, nmd, amd_s;

  always_comb begin
    an_s = num[VW-1] ? -num : num;
    ad_s = dvs[VW-1] ? -dvs : dvs;
    nmd = clamp_lim(XW'(num) - XW'(dvs));
    amd_s = nmd[VW-1] ? -nmd : nmd;
    sd4_next = sd3;
    sd4_next.sdist = rnd(num);
    sd4_next.par = (dvs == '0);
    sd4_next.neg = num[VW-1] ^ dvs[VW-1];
    sd4_next.hitg = (an_s[UW-1:0] <= ad_s[UW-1:0]);
    sd4_next.sat = ((an_s[UW-1:0] >> (UW - FB)) >= ad_s[UW-1:0]);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd4 <= sd4_next;
      an4 <= an_s[UW-1:0];
      ad4 <= ad_s[UW-1:0];
      amd4 <= amd_s[SMALLW-1:0];
      sn4 <= (an_s[UW-1:SMALLW] == '0);
      smd4 <= (amd_s[UW-1:SMALLW] == '0);
    end
  end

  // S5: scale by 1e9
  logic                v5;
  side_t               sd5;
  logic [UW-1:0]       an5, ad5;
  logic [EPSW-1:0]     m1, m2;
  logic                sn5, smd5;

  always_ff @(posedge clk) begin
    if (en) begin
      sd5 <= sd4;
      an5 <= an4;
      ad5 <= ad4;
      sn5 <= sn4;
      smd5 <= smd4;
      m1 <= an4[SMALLW-1:0] * EPS_INV;
      m2 <= amd4 * EPS_INV;
    end
  end

  // S6: endpoint tests
  logic  v6;
  side_t sd6_next;

  always_comb begin
    sd6_next = sd5;
    sd6_next.st = sn5 && (m1 < EPSW'(ad5));
    sd6_next.ec = smd5 && (m2 < EPSW'(ad5));
  end

  always_ff @(posedge clk) begin
    if (en) begin
      side_out <= sd6_next;
      an_out <= an5;
      ad_out <= ad5;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
      v6 <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
      v6 <= v5;
    end
  end

  assign out_valid = v6;

endmodule
`default_nettype wire

### design/psi_div.sv
`default_nettype none
module psi_div
  import psi_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          en,
  input  logic          in_valid,
  input  logic [UW-1:0] an,
  input  logic [UW-1:0] ad,
  input  side_t         side_in,
  output logic          out_valid,
  output logic [QB-1:0] q_out,
  output side_t         side_out
);

  // restoring divide of an * 2^FB by ad, one quotient bit per stage
  logic          v  [QB+1];
  logic [UW:0]   r  [QB+1];
  logic [UW-1:0] x  [QB+1];
  logic [QB-1:0] q  [QB+1];
  logic [UW-1:0] d  [QB+1];
  side_t         sd [QB+1];

  always_ff @(posedge clk) begin
    if (en) begin
      r[0] <= (UW+1)'(an >> (UW - FB));
      x[0] <= an << FB;
      q[0] <= '0;
      d[0] <= ad;
      sd[0] <= side_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v[0] <= 1'b0;
    end else if (en) begin
      v[0] <= in_valid;
    end
  end

  for (genvar k = 0; k < QB; k++) begin : g_stage
    logic [UW+1:0] trial;
    logic [UW+1:0] diff;
    logic          qbit;

    always_comb begin
      trial = {r[k], x[k][UW-1]};
      diff = trial - (UW+2)'(d[k]);
      qbit = (trial >= (UW+2)'(d[k]));
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r[k+1] <= qbit ? diff[UW:0] : trial[UW:0];
        x[k+1] <= x[k] << 1;
        q[k+1] <= {q[k][QB-2:0], qbit};
        d[k+1] <= d[k];
        sd[k+1] <= sd[k];
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        v[k+1] <= 1'b0;
      end else if (en) begin
        v[k+1] <= v[k];
      end
    end
  end

  assign out_valid = v[QB];
  assign q_out = q[QB];
  assign side_out = sd[QB];

endmodule
`default_nettype wire

### design/psi_back.sv
`default_nettype none
module psi_back
  import psi_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic                 in_valid,
  input  logic [QB-1:0]        q,
  input  side_t                side_in,
  input  logic signed [NW-1:0] nrm [3],
  output logic                 out_valid,
  output out_t                 out_data
);

  // B1: pick t, operands
  logic signed [VW-1:0] t_sel, tm;
  logic                 hit_sel;

  always_comb begin
    tm = side_in.sat ? LIM : {1'b0, q};
    priority if (side_in.cmd == CMD_PROJECT) begin
      t_sel = '0;
      hit_sel = 1'b0;
    end else if (side_in.par) begin
      t_sel = '0;
      hit_sel = 1'b0;
    end else if (side_in.st) begin
      t_sel = '0;
      hit_sel = 1'b1;
    end else if (side_in.ec) begin
      t_sel = ONE;
      hit_sel = 1'b1;
    end else begin
      t_sel = side_in.neg ? -tm : tm;
      hit_sel = side_in.hitg && !side_in.neg;
    end
  end

  logic                 v1, v2, v3;
  logic signed [AW-1:0] a1;
  logic signed [CW:0]   b1 [3];
  logic [2:0][CW-1:0]   s1, s2, s3;
  logic                 ng1, ng2, ng3;
  logic signed [CW-1:0] t1, t2, t3, d1, d2, d3;
  logic                 h1, h2, h3;

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= clamp_a((side_in.cmd == CMD_PROJECT) ? side_in.sdist : t_sel);
      for (int i = 0; i < 3; i++) begin
        b1[i] <= (side_in.cmd == CMD_PROJECT) ? (CW+1)'(nrm[i]) : $signed(side_in.ed[i]);
      end
      s1 <= side_in.s;
      ng1 <= (side_in.cmd == CMD_PROJECT);
      t1 <= sat_cw(XW'(t_sel));
      d1 <= sat_cw(XW'(side_in.sdist));
      h1 <= hit_sel;
    end
  end

  // B2: split multiply
  logic signed [PLW-1:0] ppl [3];
  logic signed [PHW-1:0] pph [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ppl[i] <= $signed({1'b0, a1[SPLIT-1:0]}) * b1[i];
        pph[i] <= $signed(a1[AW-1:SPLIT]) * b1[i];
      end
      s2 <= s1;
      ng2 <= ng1;
      t2 <= t1;
      d2 <= d1;
      h2 <= h1;
    end
  end

  // B3: recombine and clamp
  logic signed [VW-1:0] pc [3];

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        pc[i] <= clamp_lim((XW'(pph[i]) <<< SPLIT) + XW'(ppl[i]));
      end
      s3 <= s2;
      ng3 <= ng2;
      t3 <= t2;
      d3 <= d2;
      h3 <= h2;
    end
  end

  // B4: round, add to start, saturate into the output register
  logic signed [VW-1:0] rr [3];
  logic signed [VW:0]   rn [3];
  logic signed [CW-1:0] pt [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rr[i] = rnd(pc[i]);
      rn[i] = ng3 ? -(VW+1)'(rr[i]) : (VW+1)'(rr[i]);
      pt[i] = sat_cw(XW'($signed(s3[i])) + XW'(rn[i]));
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data.point_x <= pt[0];
      out_data.point_y <= pt[1];
      out_data.point_z <= pt[2];
      out_data.t_value <= t3;
      out_data.hit <= h3;
      out_data.signed_distance <= d3;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      out_valid <= v3;
    end
  end

endmodule
`default_nettype wire
